[src/ble_pkg.sv]
// ----------------------------------------------------------------------------
// ble_pkg: shared types and constants for the bounded list engine
// Sizes of the list, command and status codes, and the per-cell control word.
// ----------------------------------------------------------------------------
`default_nettype none

package ble_pkg;

	// list geometry
	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 16;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	// fixed field widths of the request and result
	localparam int CMD_W  = 4;
	localparam int POS_W  = 5;
	localparam int VAL_W  = 16;
	localparam int STAT_W = 2;
	localparam int FIDX_W = 4;
	localparam int LEN_W  = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_INIT    = 4'd0,
		CMD_APPEND  = 4'd1,
		CMD_INSERT  = 4'd2,
		CMD_REVERSE = 4'd3,
		CMD_CLEAR   = 4'd4,
		CMD_FIND    = 4'd5,
		CMD_REMOVE  = 4'd6,
		CMD_DELETE  = 4'd7,
		CMD_READ    = 4'd8
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_BAD_POS   = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// what every cell does in the execute cycle
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_INIT,
		CELL_APPEND,
		CELL_INSERT,
		CELL_DROP,
		CELL_REVERSE
	} cell_op_t;

	typedef struct packed {
		cell_op_t               op;
		logic [CNT_W-1:0]       pos;
		logic [CNT_W-1:0]       cnt;
		logic [DATA_WIDTH-1:0]  value;
	} cell_ctl_t;

endpackage

`default_nettype wire

[src/ble_cell.sv]
// ----------------------------------------------------------------------------
// ble_cell: one storage cell of the list
// Holds one entry, compares it with the broadcast value and updates itself
// from its neighbours, its mirror partner, the broadcast value or its own index.
// ----------------------------------------------------------------------------
`default_nettype none

module ble_cell (
	input  wire                                clk,
	input  wire logic [ble_pkg::IDX_W-1:0]     idx,
	input  wire ble_pkg::cell_ctl_t            ctl,
	input  wire logic [ble_pkg::DATA_WIDTH-1:0] left,
	input  wire logic [ble_pkg::DATA_WIDTH-1:0] right,
	input  wire logic [ble_pkg::DATA_WIDTH-1:0] mirror,
	output logic [ble_pkg::DATA_WIDTH-1:0]     entry,
	output logic                               match
);
	import ble_pkg::*;

	logic [DATA_WIDTH-1:0] entry_q;
	logic [DATA_WIDTH-1:0] entry_d;
	logic [CNT_W-1:0]      idx_ext;
	logic                  live;

	assign idx_ext = CNT_W'(idx);
	assign live    = idx_ext < ctl.cnt;

	// hit against the broadcast value, live entries only
	assign match = live && (entry_q == ctl.value);
	assign entry = entry_q;

	// next entry value
	always_comb begin
		entry_d = entry_q;
		unique case (ctl.op)
			CELL_HOLD: entry_d = entry_q;
			CELL_INIT: begin
				if (idx_ext < ctl.pos)
					entry_d = DATA_WIDTH'(idx);
			end
			CELL_APPEND: begin
				if (idx_ext == ctl.cnt)
					entry_d = ctl.value;
			end
			CELL_INSERT: begin
				if (idx_ext == ctl.pos)
					entry_d = ctl.value;
				else if (idx_ext > ctl.pos && idx_ext <= ctl.cnt)
					entry_d = left;
			end
			CELL_DROP: begin
				if (idx_ext >= ctl.pos && (idx_ext + CNT_W'(1)) < ctl.cnt)
					entry_d = right;
			end
			CELL_REVERSE: begin
				if (live)
					entry_d = mirror;
			end
			default: entry_d = entry_q;
		endcase
	end

	// entry storage, no reset needed
	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

`default_nettype wire

[src/bounded_list_engine_unit.sv]
// ----------------------------------------------------------------------------
// bounded_list_engine_unit: fixed-capacity ordered list engine
// Runs one list command per request over a row of storage cells and returns
// status, found index, read value and length.
// ----------------------------------------------------------------------------
// The edge that accepts a request latches the command, the next cycle
// compares all cells at once and updates the row, and the result then sits
// on the result ports with done high for one cycle. busy is high only in
// that execute cycle, so a new request can be taken in the same cycle that
// a result is shown; a start while busy is not taken.
// The receiver cannot stall results: sample them whenever done is high.
// List entries come up undefined after reset and the length comes up zero.
`default_nettype none

module bounded_list_engine_unit (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	output logic                              busy,
	input  wire logic [ble_pkg::CMD_W-1:0]    command,
	input  wire logic [ble_pkg::POS_W-1:0]    position,
	input  wire logic [ble_pkg::VAL_W-1:0]    item_value,
	output logic                              done,
	output logic [ble_pkg::STAT_W-1:0]        status,
	output logic [ble_pkg::FIDX_W-1:0]        found_index,
	output logic [ble_pkg::VAL_W-1:0]         read_value,
	output logic [ble_pkg::LEN_W-1:0]         list_length
);
	import ble_pkg::*;

	logic                  exec_q;
	logic                  done_q;
	logic [CMD_W-1:0]      cmd_q;
	logic [POS_W-1:0]      pos_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [CNT_W-1:0]      count_q;

	logic [STAT_W-1:0]     status_q;
	logic [FIDX_W-1:0]     fidx_q;
	logic [VAL_W-1:0]      rval_q;

	logic [DATA_WIDTH-1:0] ent    [CAPACITY];
	logic [DATA_WIDTH-1:0] mirror [CAPACITY];
	logic [CAPACITY-1:0]   hit;

	logic [IDX_W-1:0]      first_idx;
	logic [IDX_W-1:0]      last_idx;
	logic                  any_hit;
	logic                  full;
	logic [CNT_W-1:0]      pos_ext;

	cell_ctl_t             ctl;
	logic [CNT_W-1:0]      count_d;
	logic [STAT_W-1:0]     status_d;
	logic [FIDX_W-1:0]     fidx_d;
	logic [VAL_W-1:0]      rval_d;

	assign busy = exec_q;
	assign done = done_q;
	assign status      = status_q;
	assign found_index = fidx_q;
	assign read_value  = rval_q;
	assign list_length = LEN_W'(count_q);

	// request capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exec_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			exec_q <= start && !exec_q;
			done_q <= exec_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !exec_q) begin
			cmd_q <= command;
			pos_q <= position;
			val_q <= DATA_WIDTH'(item_value);
		end
	end

	// row of cells, each linked to its neighbours and its mirror partner
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [CNT_W-1:0]      mir_idx;
		logic [DATA_WIDTH-1:0] left_w;
		logic [DATA_WIDTH-1:0] right_w;

		assign mir_idx   = count_q - CNT_W'(1) - CNT_W'(i);
		assign mirror[i] = ent[mir_idx[IDX_W-1:0]];

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = ent[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = ent[i+1];
		end

		ble_cell u_cell (
			.clk    (clk),
			.idx    (IDX_W'(i)),
			.ctl    (ctl),
			.left   (left_w),
			.right  (right_w),
			.mirror (mirror[i]),
			.entry  (ent[i]),
			.match  (hit[i])
		);
	end

	// first and last matching cell
	always_comb begin
		first_idx = '0;
		last_idx  = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (hit[i])
				first_idx = IDX_W'(i);
		end
		for (int i = 0; i < CAPACITY; i++) begin
			if (hit[i])
				last_idx = IDX_W'(i);
		end
	end

	assign any_hit = |hit;
	assign full    = count_q >= CNT_W'(CAPACITY);
	assign pos_ext = CNT_W'(pos_q);

	// command decode: cell control, new length and result
	always_comb begin
		ctl.op    = CELL_HOLD;
		ctl.pos   = pos_ext;
		ctl.cnt   = count_q;
		ctl.value = val_q;
		count_d   = count_q;
		status_d  = ST_OK;
		fidx_d    = '0;
		rval_d    = '0;
		unique case (cmd_q)
			CMD_INIT: begin
				if (int'(pos_q) > CAPACITY) begin
					status_d = ST_BAD_POS;
				end else begin
					ctl.op  = CELL_INIT;
					count_d = pos_ext;
				end
			end
			CMD_APPEND: begin
				if (full) begin
					status_d = ST_OVERFLOW;
				end else begin
					ctl.op  = CELL_APPEND;
					count_d = count_q + CNT_W'(1);
				end
			end
			CMD_INSERT: begin
				if (full) begin
					status_d = ST_OVERFLOW;
				end else if (pos_ext > count_q || int'(pos_q) > CAPACITY) begin
					status_d = ST_BAD_POS;
				end else begin
					ctl.op  = CELL_INSERT;
					count_d = count_q + CNT_W'(1);
				end
			end
			CMD_REVERSE: ctl.op = CELL_REVERSE;
			CMD_CLEAR:   count_d = '0;
			CMD_FIND: begin
				if (any_hit)
					fidx_d = FIDX_W'(last_idx);
				else
					status_d = ST_NOT_FOUND;
			end
			CMD_REMOVE: begin
				if (any_hit) begin
					ctl.op  = CELL_DROP;
					ctl.pos = CNT_W'(first_idx);
					count_d = count_q - CNT_W'(1);
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			CMD_DELETE: begin
				if (int'(pos_q) >= int'(count_q)) begin
					status_d = ST_BAD_POS;
				end else begin
					ctl.op  = CELL_DROP;
					count_d = count_q - CNT_W'(1);
				end
			end
			CMD_READ: begin
				if (int'(pos_q) >= int'(count_q))
					status_d = ST_BAD_POS;
				else
					rval_d = VAL_W'(ent[pos_q[IDX_W-1:0]]);
			end
			default: ;
		endcase
		if (!exec_q)
			ctl.op = CELL_HOLD;
	end

	// length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (exec_q) begin
			count_q <= count_d;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (exec_q) begin
			status_q <= status_d;
			fidx_q   <= fidx_d;
			rval_q   <= rval_d;
		end
	end

endmodule

`default_nettype wire
